### rtl/core/ray_midpoint_triangulation_top_macros.svh
// Assertion macros for the ray midpoint triangulation block
`ifndef RAY_MIDPOINT_TRIANGULATION_TOP_MACROS_SVH
`define RAY_MIDPOINT_TRIANGULATION_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RMT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rmt_pkg.sv
// Shared constants for the ray midpoint triangulation block
package rmt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIR_WIDTH_DEF   = 16;
  localparam int THR_WIDTH       = 32;
  localparam int THR_RESET       = 1;
  localparam int MUL_CHUNK       = 24;
  localparam int PAR_SCALE       = 2000;
  localparam int PAR_SCALE_W     = 12;
  localparam int COORD_FRAC      = 16;

endpackage

### rtl/core/rmt_mul.sv
// Two-stage signed multiplier, operand b split into chunks
module rmt_mul import rmt_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int CH = MUL_CHUNK
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NK  = (BW + CH - 1) / CH;
  localparam int XW  = NK * CH;
  localparam int PPW = AW + CH + 1;
  localparam int SW  = XW + AW;

  logic signed [XW-1:0]    bx;
  logic signed [PPW-1:0]   pp_d [NK];
  logic signed [PPW-1:0]   pp_q [NK];
  logic signed [SW-1:0]    acc;
  logic signed [AW+BW-1:0] p_q;

  assign bx = XW'(b_i);

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      if (k == NK - 1) begin
        pp_d[k] = PPW'(a_i) * PPW'($signed(bx[k*CH +: CH]));
      end else begin
        pp_d[k] = PPW'(a_i) * PPW'($signed({1'b0, bx[k*CH +: CH]}));
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NK; k++) begin
      acc = acc + (SW'(pp_q[k]) <<< (k * CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
      p_q  <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/ray_midpoint_triangulation_top.sv
// Two-ray midpoint triangulation, fully pipelined top level
// Throughput: one item per cycle while the output is not stalled; ten arithmetic stages, then one stage per quotient
// bit in three restoring dividers (one per axis) plus an overflow check stage.
// A stall at the output freezes the whole pipeline.
// Reset clears the valid pipeline and sets the threshold to 1; no clearing pass.
`include "ray_midpoint_triangulation_top_macros.svh"
module ray_midpoint_triangulation_top import rmt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIR_WIDTH   = DIR_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [THR_WIDTH-1:0]          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] left_origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] left_origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] left_origin_z_i,
  input  logic signed [DIR_WIDTH-1:0]   left_dir_x_i,
  input  logic signed [DIR_WIDTH-1:0]   left_dir_y_i,
  input  logic signed [DIR_WIDTH-1:0]   left_dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] right_origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] right_origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] right_origin_z_i,
  input  logic signed [DIR_WIDTH-1:0]   right_dir_x_i,
  input  logic signed [DIR_WIDTH-1:0]   right_dir_y_i,
  input  logic signed [DIR_WIDTH-1:0]   right_dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  output logic signed [COORD_WIDTH-1:0] point_z_o,
  output logic                          rays_parallel_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int F    = DW - 2;
  localparam int W0W  = CW + 1;
  localparam int PDW  = 2 * DW;
  localparam int ABW  = 2 * DW + 2;
  localparam int DPW  = DW + CW + 1;
  localparam int DEW  = DW + CW + 3;
  localparam int DENW = 2 * ABW;
  localparam int NSW  = ABW + DEW + 1;
  localparam int SDW  = W0W + DENW;
  localparam int NLW  = DW + NSW;
  localparam int NW   = ((SDW > NLW) ? SDW : NLW) + 2;
  localparam int DDW  = DENW + 1;
  localparam int TW   = THR_WIDTH + 2 * F;
  localparam int CMPW = (DENW > TW) ? DENW : TW;
  localparam int PSW  = DW + PAR_SCALE_W;
  localparam int QW   = CW - 1;
  localparam int NST  = CW + 10;

  localparam logic signed [PAR_SCALE_W-1:0] PAR_K = PAR_SCALE_W'(PAR_SCALE);

  logic en;
  logic [NST-1:0] vld_q;
  logic [THR_WIDTH-1:0] thr_q;

  logic signed [CW-1:0] pl [3];
  logic signed [CW-1:0] pr [3];
  logic signed [DW-1:0] dl [3];
  logic signed [DW-1:0] dr [3];

  assign pl[0] = left_origin_x_i;
  assign pl[1] = left_origin_y_i;
  assign pl[2] = left_origin_z_i;
  assign pr[0] = right_origin_x_i;
  assign pr[1] = right_origin_y_i;
  assign pr[2] = right_origin_z_i;
  assign dl[0] = left_dir_x_i;
  assign dl[1] = left_dir_y_i;
  assign dl[2] = left_dir_z_i;
  assign dr[0] = right_dir_x_i;
  assign dr[1] = right_dir_y_i;
  assign dr[2] = right_dir_z_i;

  assign en         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= THR_WIDTH'(THR_RESET);
    end else begin
      if (en) begin
        vld_q <= {vld_q[NST-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // stage 1: origin sum and difference, direction products
  logic signed [W0W-1:0] s1_w0_q [3];
  logic signed [W0W-1:0] s1_s_q  [3];
  logic signed [PDW-1:0] s1_aa_q [3];
  logic signed [PDW-1:0] s1_bb_q [3];
  logic signed [PDW-1:0] s1_cc_q [3];
  logic signed [DW-1:0]  s1_dl_q [3];
  logic signed [DW-1:0]  s1_dr_q [3];

  // stage 2: a, b, c; products for d, e
  logic signed [ABW-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic signed [DPW-1:0] s2_dp_q [3];
  logic signed [DPW-1:0] s2_ep_q [3];
  logic signed [W0W-1:0] s2_s_q  [3];
  logic signed [DW-1:0]  s2_dl_q [3];
  logic signed [DW-1:0]  s2_dr_q [3];

  // stage 3: d, e
  logic signed [ABW-1:0] s3_a_q, s3_b_q, s3_c_q;
  logic signed [DEW-1:0] s3_d_q, s3_e_q;
  logic signed [W0W-1:0] s3_s_q  [3];
  logic signed [DW-1:0]  s3_dl_q [3];
  logic signed [DW-1:0]  s3_dr_q [3];

  // stage 4
  logic signed [W0W-1:0] s4_s_q  [3];
  logic signed [DW-1:0]  s4_dl_q [3];
  logic signed [DW-1:0]  s4_dr_q [3];

  // stage 5: denominator
  logic signed [DENW-1:0] s5_den_q;
  logic signed [W0W-1:0]  s5_s_q  [3];
  logic signed [DW-1:0]   s5_dl_q [3];
  logic signed [DW-1:0]   s5_dr_q [3];

  // stage 6: numerators of sc and tc, parallel test
  logic signed [NSW-1:0]  s6_nsc_q, s6_ntc_q;
  logic signed [DENW-1:0] s6_den_q;
  logic                   s6_par_q;
  logic signed [W0W-1:0]  s6_s_q  [3];
  logic signed [DW-1:0]   s6_dl_q [3];
  logic signed [DW-1:0]   s6_dr_q [3];

  // stages 7 to 9
  logic signed [DENW-1:0] s7_den_q, s8_den_q, s9_den_q;
  logic                   s7_par_q, s8_par_q, s9_par_q;
  logic signed [W0W-1:0]  s7_s_q  [3];
  logic signed [PSW-1:0]  s7_dm_q [3];
  logic signed [NW-1:0]   s8_pn_q [3];
  logic signed [NW-1:0]   s9_pn_q [3];
  logic signed [NW-1:0]   s9_a_q  [3];
  logic signed [NW-1:0]   s9_b_q  [3];

  // stage 10: divider operands
  logic signed [NW-1:0] n10 [3];
  logic [NW-1:0]        s10_u_q   [3];
  logic                 s10_neg_q [3];
  logic [DDW-1:0]       s10_dd_q;
  logic                 s10_par_q;

  // multiplier outputs
  logic signed [DENW-1:0]    p_ac, p_bb;
  logic signed [ABW+DEW-1:0] p_be, p_cd, p_ae, p_bd;
  logic signed [SDW-1:0]     p_sd [3];
  logic signed [NLW-1:0]     p_nl [3];
  logic signed [NLW-1:0]     p_nr [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_w0_q[i] <= W0W'(pl[i]) - W0W'(pr[i]);
        s1_s_q[i]  <= W0W'(pl[i]) + W0W'(pr[i]);
        s1_aa_q[i] <= PDW'(dl[i]) * PDW'(dl[i]);
        s1_bb_q[i] <= PDW'(dl[i]) * PDW'(dr[i]);
        s1_cc_q[i] <= PDW'(dr[i]) * PDW'(dr[i]);
        s1_dl_q[i] <= dl[i];
        s1_dr_q[i] <= dr[i];

        s2_dp_q[i] <= DPW'(s1_dl_q[i]) * DPW'(s1_w0_q[i]);
        s2_ep_q[i] <= DPW'(s1_dr_q[i]) * DPW'(s1_w0_q[i]);
        s2_s_q[i]  <= s1_s_q[i];
        s2_dl_q[i] <= s1_dl_q[i];
        s2_dr_q[i] <= s1_dr_q[i];

        s3_s_q[i]  <= s2_s_q[i];
        s3_dl_q[i] <= s2_dl_q[i];
        s3_dr_q[i] <= s2_dr_q[i];

        s4_s_q[i]  <= s3_s_q[i];
        s4_dl_q[i] <= s3_dl_q[i];
        s4_dr_q[i] <= s3_dr_q[i];

        s5_s_q[i]  <= s4_s_q[i];
        s5_dl_q[i] <= s4_dl_q[i];
        s5_dr_q[i] <= s4_dr_q[i];

        s6_s_q[i]  <= s5_s_q[i];
        s6_dl_q[i] <= s5_dl_q[i];
        s6_dr_q[i] <= s5_dr_q[i];

        s7_s_q[i]  <= s6_s_q[i];
        s7_dm_q[i] <= PSW'(s6_dl_q[i]) * PSW'(PAR_K);

        s8_pn_q[i] <= (NW'(s7_s_q[i]) <<< F) + (NW'(s7_dm_q[i]) <<< COORD_FRAC)
                      + (NW'(1) <<< F);

        s9_a_q[i]  <= NW'(p_sd[i]) + NW'(p_nl[i]);
        s9_b_q[i]  <= NW'(p_nr[i]) + NW'(s8_den_q);
        s9_pn_q[i] <= s8_pn_q[i];

        s10_u_q[i]   <= n10[i] ^ {NW{n10[i][NW-1]}};
        s10_neg_q[i] <= n10[i][NW-1];
      end

      s2_a_q <= ABW'(s1_aa_q[0]) + ABW'(s1_aa_q[1]) + ABW'(s1_aa_q[2]);
      s2_b_q <= ABW'(s1_bb_q[0]) + ABW'(s1_bb_q[1]) + ABW'(s1_bb_q[2]);
      s2_c_q <= ABW'(s1_cc_q[0]) + ABW'(s1_cc_q[1]) + ABW'(s1_cc_q[2]);

      s3_a_q <= s2_a_q;
      s3_b_q <= s2_b_q;
      s3_c_q <= s2_c_q;
      s3_d_q <= DEW'(s2_dp_q[0]) + DEW'(s2_dp_q[1]) + DEW'(s2_dp_q[2]);
      s3_e_q <= DEW'(s2_ep_q[0]) + DEW'(s2_ep_q[1]) + DEW'(s2_ep_q[2]);

      // a*c >= b*b for integer vectors, so den is never negative
      s5_den_q <= p_ac - p_bb;

      s6_nsc_q <= NSW'(p_be) - NSW'(p_cd);
      s6_ntc_q <= NSW'(p_ae) - NSW'(p_bd);
      s6_den_q <= s5_den_q;
      s6_par_q <= CMPW'($unsigned(s5_den_q)) <= (CMPW'(thr_q) << (2 * F));

      s7_den_q <= s6_den_q;
      s7_par_q <= s6_par_q;
      s8_den_q <= s7_den_q;
      s8_par_q <= s7_par_q;
      s9_den_q <= s8_den_q;
      s9_par_q <= s8_par_q;

      s10_dd_q  <= s9_par_q ? (DDW'(1) << (F + 1)) : {s9_den_q, 1'b0};
      s10_par_q <= s9_par_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n10[i] = s9_par_q ? s9_pn_q[i] : s9_a_q[i] + s9_b_q[i];
    end
  end

  rmt_mul #(.AW(ABW), .BW(ABW), .CH(MUL_CHUNK)) u_mul_ac (
    .clk_i(clk_i), .en_i(en), .a_i(s2_a_q), .b_i(s2_c_q), .p_o(p_ac)
  );
  rmt_mul #(.AW(ABW), .BW(ABW), .CH(MUL_CHUNK)) u_mul_bb (
    .clk_i(clk_i), .en_i(en), .a_i(s2_b_q), .b_i(s2_b_q), .p_o(p_bb)
  );
  rmt_mul #(.AW(ABW), .BW(DEW), .CH(MUL_CHUNK)) u_mul_be (
    .clk_i(clk_i), .en_i(en), .a_i(s3_b_q), .b_i(s3_e_q), .p_o(p_be)
  );
  rmt_mul #(.AW(ABW), .BW(DEW), .CH(MUL_CHUNK)) u_mul_cd (
    .clk_i(clk_i), .en_i(en), .a_i(s3_c_q), .b_i(s3_d_q), .p_o(p_cd)
  );
  rmt_mul #(.AW(ABW), .BW(DEW), .CH(MUL_CHUNK)) u_mul_ae (
    .clk_i(clk_i), .en_i(en), .a_i(s3_a_q), .b_i(s3_e_q), .p_o(p_ae)
  );
  rmt_mul #(.AW(ABW), .BW(DEW), .CH(MUL_CHUNK)) u_mul_bd (
    .clk_i(clk_i), .en_i(en), .a_i(s3_b_q), .b_i(s3_d_q), .p_o(p_bd)
  );

  for (genvar g = 0; g < 3; g++) begin : g_axis_mul
    rmt_mul #(.AW(W0W), .BW(DENW), .CH(MUL_CHUNK)) u_mul_sd (
      .clk_i(clk_i), .en_i(en), .a_i(s6_s_q[g]), .b_i(s6_den_q), .p_o(p_sd[g])
    );
    rmt_mul #(.AW(DW), .BW(NSW), .CH(MUL_CHUNK)) u_mul_nl (
      .clk_i(clk_i), .en_i(en), .a_i(s6_dl_q[g]), .b_i(s6_nsc_q), .p_o(p_nl[g])
    );
    rmt_mul #(.AW(DW), .BW(NSW), .CH(MUL_CHUNK)) u_mul_nr (
      .clk_i(clk_i), .en_i(en), .a_i(s6_dr_q[g]), .b_i(s6_ntc_q), .p_o(p_nr[g])
    );
  end

  // restoring dividers: stage 0 checks overflow, then one quotient bit per stage
  logic [NW-1:0]  dv_r_q   [CW][3];
  logic [QW-1:0]  dv_q_q   [CW][3];
  logic           dv_neg_q [CW][3];
  logic [DDW-1:0] dv_dd_q  [CW];
  logic           dv_par_q [CW];
  logic [NW-1:0]  dv_top;

  assign dv_top = NW'(s10_dd_q) << QW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_neg_q[0][i] <= s10_neg_q[i];
        if (s10_u_q[i] >= dv_top) begin
          dv_r_q[0][i] <= '0;
          dv_q_q[0][i] <= '1;
        end else begin
          dv_r_q[0][i] <= s10_u_q[i];
          dv_q_q[0][i] <= '0;
        end
      end
      dv_dd_q[0]  <= s10_dd_q;
      dv_par_q[0] <= s10_par_q;
    end
  end

  for (genvar j = 1; j < CW; j++) begin : g_div
    localparam int B = QW - j;
    logic [NW-1:0] sub;

    assign sub = NW'(dv_dd_q[j-1]) << B;

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_neg_q[j][i] <= dv_neg_q[j-1][i];
          if (dv_r_q[j-1][i] >= sub) begin
            dv_r_q[j][i] <= dv_r_q[j-1][i] - sub;
            dv_q_q[j][i] <= dv_q_q[j-1][i] | (QW'(1) << B);
          end else begin
            dv_r_q[j][i] <= dv_r_q[j-1][i];
            dv_q_q[j][i] <= dv_q_q[j-1][i];
          end
        end
        dv_dd_q[j]  <= dv_dd_q[j-1];
        dv_par_q[j] <= dv_par_q[j-1];
      end
    end
  end

  // negative numerators were complemented, so the quotient is complemented back
  assign point_x_o = dv_neg_q[CW-1][0] ? ~{1'b0, dv_q_q[CW-1][0]} : {1'b0, dv_q_q[CW-1][0]};
  assign point_y_o = dv_neg_q[CW-1][1] ? ~{1'b0, dv_q_q[CW-1][1]} : {1'b0, dv_q_q[CW-1][1]};
  assign point_z_o = dv_neg_q[CW-1][2] ? ~{1'b0, dv_q_q[CW-1][2]} : {1'b0, dv_q_q[CW-1][2]};
  assign rays_parallel_o = dv_par_q[CW-1];
  assign out_valid_o     = vld_q[NST-1];

  `RMT_ASSERT_NXT(a_stall_holds, !en, $stable(vld_q), "pipeline moved during stall")
  `RMT_ASSERT_IMP(a_den_nonneg, vld_q[4], !s5_den_q[DENW-1], "negative denominator")
  `RMT_ASSERT_IMP(a_div_nonzero, vld_q[9], s10_dd_q != '0, "zero divisor")
  `RMT_ASSERT_IMP(a_rem_below, vld_q[NST-1], dv_r_q[CW-1][0] < NW'(dv_dd_q[CW-1]), "remainder too big")

endmodule

### verif/ray_midpoint_triangulation_top_tb.sv
// Testbench for the two-ray midpoint triangulation block: random and directed ray pairs
`timescale 1ns / 1ps
module ray_midpoint_triangulation_top_tb import rmt_pkg::*;;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DW = DIR_WIDTH_DEF;
  localparam int DFRAC = DW - 2;
  localparam int LATENCY = CW + 10;

  typedef logic signed [127:0] w_t;

  typedef struct {
    logic signed [CW-1:0] lo[3];
    logic signed [DW-1:0] ld[3];
    logic signed [CW-1:0] ro[3];
    logic signed [DW-1:0] rd[3];
  } ray_pair_t;

  typedef struct {
    logic signed [CW-1:0] p[3];
    logic                 par;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] lox = '0, loy = '0, loz = '0, rox = '0, roy = '0, roz = '0;
  logic signed [DW-1:0] ldx = '0, ldy = '0, ldz = '0, rdx = '0, rdy = '0, rdz = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] point_x_o, point_y_o, point_z_o;
  logic rays_parallel_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ray_midpoint_triangulation_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .left_origin_x_i(lox), .left_origin_y_i(loy), .left_origin_z_i(loz),
    .left_dir_x_i(ldx), .left_dir_y_i(ldy), .left_dir_z_i(ldz),
    .right_origin_x_i(rox), .right_origin_y_i(roy), .right_origin_z_i(roz),
    .right_dir_x_i(rdx), .right_dir_y_i(rdy), .right_dir_z_i(rdz),
    .out_valid_o, .out_ready_i, .point_x_o, .point_y_o, .point_z_o, .rays_parallel_o
  );

  logic [THR_WIDTH-1:0] threshold = THR_RESET;
  point_t expected_points[$];
  int errors = 0, pairs_sent = 0, points_seen = 0, parallel_seen = 0;
  bit calm_sender = 0, calm_receiver = 0;

  function automatic w_t floor_div(w_t n, w_t d);
    w_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [CW-1:0] saturate(w_t v);
    w_t top, bot;
    top = (w_t'(1) <<< (CW - 1)) - 1;
    bot = -(w_t'(1) <<< (CW - 1));
    if (v > top) v = top;
    if (v < bot) v = bot;
    return v[CW-1:0];
  endfunction

  function automatic point_t triangulate(ray_pair_t r);
    w_t pl[3], dl[3], pr[3], dr[3], w0[3];
    w_t a, b, c, d, e, den, mag, thr, nsc, ntc, num;
    point_t res;
    for (int i = 0; i < 3; i++) begin
      pl[i] = r.lo[i];
      dl[i] = r.ld[i];
      pr[i] = r.ro[i];
      dr[i] = r.rd[i];
      w0[i] = pl[i] - pr[i];
    end
    a = dl[0]*dl[0] + dl[1]*dl[1] + dl[2]*dl[2];
    b = dl[0]*dr[0] + dl[1]*dr[1] + dl[2]*dr[2];
    c = dr[0]*dr[0] + dr[1]*dr[1] + dr[2]*dr[2];
    d = dl[0]*w0[0] + dl[1]*w0[1] + dl[2]*w0[2];
    e = dr[0]*w0[0] + dr[1]*w0[1] + dr[2]*w0[2];
    den = a*c - b*b;
    mag = den < 0 ? -den : den;
    thr = w_t'({96'b0, threshold}) <<< (2 * DFRAC);
    res.par = mag <= thr;
    if (res.par) begin
      for (int i = 0; i < 3; i++) begin
        num = ((pl[i] + pr[i]) <<< DFRAC) + ((dl[i] * PAR_SCALE) <<< 16);
        res.p[i] = saturate(floor_div(num + (w_t'(1) <<< DFRAC), w_t'(1) <<< (DFRAC + 1)));
      end
    end else begin
      nsc = b*e - c*d;
      ntc = a*e - b*d;
      if (den < 0) begin
        nsc = -nsc;
        ntc = -ntc;
      end
      for (int i = 0; i < 3; i++) begin
        num = (pl[i] + pr[i]) * mag + nsc * dl[i] + ntc * dr[i];
        res.p[i] = saturate(floor_div(num + mag, mag + mag));
      end
    end
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(string what, logic signed [CW-1:0] got, logic signed [CW-1:0] want);
    errors++;
    $display("mismatch on %s at item %0d: got %0d want %0d", what, points_seen, got, want);
  endtask

  task automatic send_pair(ray_pair_t r);
    int gap;
    gap = calm_sender ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    lox <= r.lo[0]; loy <= r.lo[1]; loz <= r.lo[2];
    ldx <= r.ld[0]; ldy <= r.ld[1]; ldz <= r.ld[2];
    rox <= r.ro[0]; roy <= r.ro[1]; roz <= r.ro[2];
    rdx <= r.rd[0]; rdy <= r.rd[1]; rdz <= r.rd[2];
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    expected_points.push_back(triangulate(r));
    pairs_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_points.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [THR_WIDTH-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  always @(posedge clk_i) begin
    if (calm_receiver) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 99) < 4) out_ready_i <= 1'b0;
    else if (!out_ready_i && $urandom_range(0, 99) < 10) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) < 75);
  end

  always @(negedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report("unexpected point", point_x_o, '0);
      end else begin
        want = expected_points.pop_front();
        if (point_x_o !== want.p[0]) report("point_x", point_x_o, want.p[0]);
        if (point_y_o !== want.p[1]) report("point_y", point_y_o, want.p[1]);
        if (point_z_o !== want.p[2]) report("point_z", point_z_o, want.p[2]);
        if (rays_parallel_o !== want.par) begin
          report("rays_parallel", CW'(rays_parallel_o), CW'(want.par));
        end
        if (want.par) parallel_seen++;
      end
      points_seen++;
    end
  end

  function automatic ray_pair_t random_pair(int kind);
    ray_pair_t r;
    for (int i = 0; i < 3; i++) begin
      r.lo[i] = $urandom;
      r.ro[i] = $urandom;
      r.ld[i] = DW'($urandom);
      r.rd[i] = DW'($urandom);
      if (kind >= 1) begin
        r.lo[i] = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        r.ro[i] = r.lo[i] + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        r.ld[i] = DW'($signed($urandom_range(0, 32767)) - 16'sd16384);
      end
      if (kind == 2) r.rd[i] = DW'(r.ld[i] + $signed($urandom_range(0, 8)) - 16'sd4);
      else if (kind >= 1) r.rd[i] = DW'($signed($urandom_range(0, 32767)) - 16'sd16384);
    end
    if (kind == 3) begin
      r.ld = '{0, 0, 0};
      if ($urandom_range(0, 1)) r.rd = '{0, 0, 0};
    end
    return r;
  endfunction

  task automatic test_directed();
    ray_pair_t r;
    r.lo = '{0, 0, 0}; r.ro = '{32'sh0001_0000, 0, 0};
    r.ld = '{0, 0, 16384}; r.rd = '{0, 16384, 0};
    send_pair(r);
    r.rd = '{0, 0, 16384};
    send_pair(r);
    r.ld = '{0, 0, 0}; r.rd = '{0, 0, 0};
    send_pair(r);
    r.lo = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    r.ro = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
    r.ld = '{16'sh7FFF, 16'sh8000, 16'sh7FFF}; r.rd = '{16'sh8000, 16'sh7FFF, 16'sh7FFF};
    send_pair(r);
    r.rd = r.ld;
    send_pair(r);
    r.ld = '{16'sh8000, 16'sh8000, 16'sh8000}; r.rd = '{16'sh8000, 16'sh8000, 16'sh8000};
    send_pair(r);
    r.lo = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    r.ro = r.lo; r.rd = '{16'sh7FFF, 16'sh8000, 0};
    send_pair(r);
    r.lo = '{-1, -1, -1}; r.ro = '{0, 0, 0};
    r.ld = '{1, 0, 0}; r.rd = '{0, 1, 0};
    send_pair(r);
    r.ld = '{1, 1, 0}; r.rd = '{1, 0, 0};
    send_pair(r);
    r.lo = '{32'sh0000_8000, 32'sh0003_0000, -32'sh0002_0000};
    r.ro = '{-32'sh0001_8000, 32'sh0000_4000, 32'sh0005_0000};
    r.ld = '{16384, 16384, 0}; r.rd = '{-16384, 16384, 8192};
    send_pair(r);
    r.rd = '{16385, 16384, 0};
    send_pair(r);
    r.ld = '{-1, -1, -1}; r.rd = '{1, -1, 1};
    send_pair(r);
  endtask

  task automatic test_random(int count, bit mostly_parallel);
    int kind, r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (mostly_parallel) kind = r < 60 ? 2 : 1;
      else kind = r < 25 ? 0 : r < 75 ? 1 : r < 92 ? 2 : 3;
      calm_sender = (n % 200) >= 170;
      calm_receiver = (n % 300) >= 250;
      send_pair(random_pair(kind));
    end
    calm_sender = 0;
    calm_receiver = 0;
    drain();
  endtask

  task automatic test_threshold_sweep();
    set_threshold(0);
    test_directed();
    test_random(120, 1);
    set_threshold(32'hFFFF_FFFF);
    test_directed();
    test_random(100, 0);
    set_threshold(32'd1 << 20);
    test_random(120, 1);
    set_threshold($urandom);
    test_random(100, 0);
    set_threshold(THR_RESET);
    test_random(100, 1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400, 0);
    drain();
    test_threshold_sweep();
    $display("sent %0d ray pairs, checked %0d points (%0d parallel fallbacks)",
             pairs_sent, points_seen, parallel_seen);
    $display("thresholds covered: reset value, zero, all ones, 2^20 and a random value");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d points missing", errors, expected_points.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d points outstanding", expected_points.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rmt_pkg.sv
rtl/core/rmt_mul.sv
rtl/core/ray_midpoint_triangulation_top.sv
verif/ray_midpoint_triangulation_top_tb.sv
